/* design/ala_pkg.sv */
// Shared types, constants and codes for the audio level analyser.
package ala_pkg;

    // Sample format and buffer size
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_SAMPLES = 262144;
    localparam int MAG_W       = SAMPLE_BITS;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = 64;
    localparam int MAN_W       = 32;
    localparam int PROD_W      = 2 * MAN_W;

    // Log arithmetic: Q16 log2, exponent of a 64-bit word
    localparam int FRAC_W      = 16;
    localparam int EXP_W       = $clog2(SUM_W);
    localparam int L_W         = EXP_W + FRAC_W;
    localparam int FRAC_CNT_W  = $clog2(FRAC_W);
    localparam int STEP_W      = $clog2(SUM_W);

    localparam logic [L_W-1:0] FULL_PEAK_Q16 = L_W'((SAMPLE_BITS - 1) * 65536);
    localparam logic [L_W-1:0] FULL_RMS_Q16  = L_W'(2 * (SAMPLE_BITS - 1) * 65536);
    localparam logic [MAN_W-1:0] TEN_LOG10_2_Q16 = MAN_W'(197283);
    localparam logic [PROD_W-1:0] ROUND_Q24 = PROD_W'(64'd1 << 23);
    localparam int DB_FLOOR_Q8 = 25600;

    // Configuration register indexes
    localparam logic CFG_SILENCE = 1'b0;
    localparam logic CFG_CLIP    = 1'b1;

    // Operand selections of the shared multiplier
    localparam logic [1:0] MUL_SAMPLE = 2'd0;
    localparam logic [1:0] MUL_MANT   = 2'd1;
    localparam logic [1:0] MUL_SCALE  = 2'd2;

    typedef struct packed {
        logic signed [23:0] sample;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] peak_db;
        logic signed [15:0] rms_db;
        logic [14:0]        dynamic_range_db;
        logic               clipping;
        logic               silent;
    } t_out_word;

    typedef struct packed {
        logic take;
        logic res_free;
    } t_core_ctrl;

    typedef struct packed {
        logic ready;
        logic res_valid;
    } t_core_stat;

endpackage

/* design/audio_level_analyzer.sv */
// Top level of the audio level analyser: ports, configuration and output register.
//
//   channel   direction  handshake                 word
//   input     in         i_in_valid / o_in_stall   i_in_word  (sample, last)
//   output    out        o_out_valid / i_out_stall o_out_word (peak, rms, range, flags)
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A sample word that is not last passes through accept, square on the shared
// multiplier and saturating add. A last word then runs the report sequence on the
// same multiplier: normalising shifts, 16 squaring rounds and 3 dB steps per
// level, plus a restoring division of the sum by the sample count; no new word
// is accepted until the report has been handed to the free output register.
// Reset is synchronous, clears the accumulators and restores the default configuration.
// A finished report waits in the output register while the next buffer is taken.
module audio_level_analyzer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ala_pkg::t_in_word     i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ala_pkg::t_out_word    o_out_word,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [23:0]           i_cfg_data
);

    logic signed [15:0]  r_silence_thr;
    logic [23:0]         r_clip_thr;
    logic                r_out_valid;
    ala_pkg::t_out_word  r_out_word;

    ala_pkg::t_core_ctrl core_ctrl;
    ala_pkg::t_core_stat core_stat;
    ala_pkg::t_out_word  core_res;

    assign core_ctrl.take     = i_in_valid && core_stat.ready;
    assign core_ctrl.res_free = !r_out_valid || !i_out_stall;

    ala_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (core_ctrl),
        .i_word        (i_in_word),
        .i_silence_thr (r_silence_thr),
        .i_clip_thr    (r_clip_thr),
        .o_stat        (core_stat),
        .o_res         (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_thr <= -16'sd15360;
            r_clip_thr    <= 24'd8380219;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ala_pkg::CFG_SILENCE: r_silence_thr <= signed'(i_cfg_data[15:0]);
                ala_pkg::CFG_CLIP:    r_clip_thr    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_stat.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.res_valid) begin
            r_out_word <= core_res;
        end
    end

    assign o_in_stall  = !core_stat.ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* design/ala_mul.sv */
// Shared 32 x 32 multiplier with its operand selection.
module ala_mul (
    input  logic [1:0]                  i_op,
    input  logic [ala_pkg::MAG_W-1:0]   i_mag,
    input  logic [ala_pkg::MAN_W-1:0]   i_man,
    input  logic [ala_pkg::L_W-1:0]     i_d,
    output logic [ala_pkg::PROD_W-1:0]  o_prod
);

    logic [ala_pkg::MAN_W-1:0] a;
    logic [ala_pkg::MAN_W-1:0] b;

    always_comb begin
        case (i_op)
            ala_pkg::MUL_SAMPLE: begin
                a = ala_pkg::MAN_W'(i_mag);
                b = ala_pkg::MAN_W'(i_mag);
            end
            ala_pkg::MUL_MANT: begin
                a = i_man;
                b = i_man;
            end
            ala_pkg::MUL_SCALE: begin
                a = ala_pkg::MAN_W'(i_d);
                b = ala_pkg::TEN_LOG10_2_Q16;
            end
            default: begin
                a = '0;
                b = '0;
            end
        endcase
    end

    assign o_prod = ala_pkg::PROD_W'(a) * ala_pkg::PROD_W'(b);

endmodule

/* design/ala_core.sv */
// Sequencer and datapath: accumulation, division, log2 and dB conversion.
module ala_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ala_pkg::t_core_ctrl         i_ctrl,
    input  ala_pkg::t_in_word           i_word,
    input  logic signed [15:0]          i_silence_thr,
    input  logic [23:0]                 i_clip_thr,
    output ala_pkg::t_core_stat         o_stat,
    output ala_pkg::t_out_word          o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_LOG   = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_DBMUL = 4'd6;
    localparam logic [3:0] S_DBRND = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int MAG_W  = ala_pkg::MAG_W;
    localparam int CNT_W  = ala_pkg::CNT_W;
    localparam int SUM_W  = ala_pkg::SUM_W;
    localparam int MAN_W  = ala_pkg::MAN_W;
    localparam int PROD_W = ala_pkg::PROD_W;
    localparam int EXP_W  = ala_pkg::EXP_W;
    localparam int FRAC_W = ala_pkg::FRAC_W;
    localparam int L_W    = ala_pkg::L_W;
    localparam int SAMPLE_BITS_W = ala_pkg::SAMPLE_BITS;

    logic [3:0]                      r_state, n_state;
    logic [MAG_W-1:0]                r_mag, n_mag;
    logic                            r_last, n_last;
    logic                            r_upd, n_upd;
    logic [MAG_W-1:0]                r_peak, n_peak;
    logic [SUM_W-1:0]                r_sum, n_sum;
    logic [CNT_W-1:0]                r_count, n_count;
    logic                            r_clip, n_clip;
    logic [PROD_W-1:0]               r_prod, n_prod;
    logic [SUM_W-1:0]                r_acc, n_acc;
    logic [EXP_W-1:0]                r_exp, n_exp;
    logic [MAN_W-1:0]                r_man, n_man;
    logic [FRAC_W-1:0]               r_frac, n_frac;
    logic [ala_pkg::FRAC_CNT_W-1:0]  r_cnt, n_cnt;
    logic [L_W-1:0]                  r_d, n_d;
    logic                            r_sel, n_sel;
    logic [CNT_W-1:0]                r_rem, n_rem;
    logic [ala_pkg::STEP_W-1:0]      r_step, n_step;
    logic signed [15:0]              r_peak_db, n_peak_db;
    logic signed [15:0]              r_rms_db, n_rms_db;

    logic [1:0]              mul_op;
    logic [PROD_W-1:0]       mul_prod;
    logic [SAMPLE_BITS_W-1:0] raw;
    logic [MAG_W-1:0]        mag;
    logic [SUM_W:0]          sum_ext;
    logic [MAN_W:0]          sq_top;
    logic [L_W-1:0]          l_val;
    logic [L_W-1:0]          full;
    logic [L_W-1:0]          d_val;
    logic [PROD_W-1:0]       rnd;
    logic [PROD_W-25:0]      q_wide;
    logic signed [15:0]      db_val;
    logic                    do_store;
    logic [CNT_W:0]          trial;
    logic                    ge;
    logic signed [16:0]      diff;
    logic [14:0]             range;
    logic                    res_valid;

    ala_mul u_mul (
        .i_op   (mul_op),
        .i_mag  (r_mag),
        .i_man  (r_man),
        .i_d    (r_d),
        .o_prod (mul_prod)
    );

    always_comb begin
        case (r_state)
            S_SQ:    mul_op = ala_pkg::MUL_SAMPLE;
            S_LOG:   mul_op = ala_pkg::MUL_MANT;
            default: mul_op = ala_pkg::MUL_SCALE;
        endcase
    end

    // Magnitude of the low SAMPLE_BITS bits; full-scale negative maps to 2^(N-1)
    assign raw = i_word.sample[SAMPLE_BITS_W-1:0];
    assign mag = raw[SAMPLE_BITS_W-1] ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);

    assign sum_ext = {1'b0, r_sum} + {1'b0, r_prod};
    assign sq_top  = mul_prod[PROD_W-1:MAN_W-1];

    assign l_val = {r_exp, r_frac};
    assign full  = r_sel ? ala_pkg::FULL_RMS_Q16 : ala_pkg::FULL_PEAK_Q16;
    assign d_val = (l_val >= full) ? '0 : (full - l_val);

    assign rnd    = r_prod + ala_pkg::ROUND_Q24;
    assign q_wide = rnd[PROD_W-1:24];

    always_comb begin
        if (r_state == S_NORM) begin
            db_val = -16'(ala_pkg::DB_FLOOR_Q8);
        end else if (q_wide > (PROD_W-24)'(ala_pkg::DB_FLOOR_Q8)) begin
            db_val = -16'(ala_pkg::DB_FLOOR_Q8);
        end else begin
            db_val = 16'sd0 - signed'(q_wide[15:0]);
        end
    end

    assign do_store = ((r_state == S_NORM) && (r_acc == '0)) || (r_state == S_DBRND);

    assign trial = {r_rem, r_acc[SUM_W-1]};
    assign ge    = (trial >= {1'b0, r_count});

    always_comb begin
        diff = 17'(r_peak_db) - 17'(r_rms_db);
        if (diff < 0) begin
            range = '0;
        end else if (diff > 17'sd25600) begin
            range = 15'(ala_pkg::DB_FLOOR_Q8);
        end else begin
            range = diff[14:0];
        end
    end

    assign res_valid = (r_state == S_OUT) && i_ctrl.res_free;

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_last    = r_last;
        n_upd     = r_upd;
        n_peak    = r_peak;
        n_sum     = r_sum;
        n_count   = r_count;
        n_clip    = r_clip;
        n_prod    = r_prod;
        n_acc     = r_acc;
        n_exp     = r_exp;
        n_man     = r_man;
        n_frac    = r_frac;
        n_cnt     = r_cnt;
        n_d       = r_d;
        n_sel     = r_sel;
        n_rem     = r_rem;
        n_step    = r_step;
        n_peak_db = r_peak_db;
        n_rms_db  = r_rms_db;

        case (r_state)
            S_IDLE: begin
                if (i_ctrl.take) begin
                    n_mag   = mag;
                    n_last  = i_word.last;
                    n_upd   = (r_count < CNT_W'(ala_pkg::MAX_SAMPLES));
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_prod = mul_prod;
                if (r_upd) begin
                    if (r_mag > r_peak) begin
                        n_peak = r_mag;
                    end
                    if (24'(r_mag) >= i_clip_thr) begin
                        n_clip = 1'b1;
                    end
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_upd) begin
                    n_sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    n_count = r_count + 1'b1;
                end
                if (r_last) begin
                    n_acc   = SUM_W'(r_peak);
                    n_exp   = EXP_W'(SUM_W - 1);
                    n_sel   = 1'b0;
                    n_state = S_NORM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NORM: begin
                // A zero word is handled by the store path below.
                if (r_acc != '0) begin
                    if (r_acc[SUM_W-1]) begin
                        n_man   = r_acc[SUM_W-1:SUM_W-MAN_W];
                        n_frac  = '0;
                        n_cnt   = '0;
                        n_state = S_LOG;
                    end else begin
                        n_acc = {r_acc[SUM_W-2:0], 1'b0};
                        n_exp = r_exp - 1'b1;
                    end
                end
            end
            S_LOG: begin
                n_frac = {r_frac[FRAC_W-2:0], sq_top[MAN_W]};
                n_man  = sq_top[MAN_W] ? sq_top[MAN_W:1] : sq_top[MAN_W-1:0];
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                // Peak is an amplitude, so its shortfall counts twice.
                n_d     = r_sel ? d_val : {d_val[L_W-2:0], 1'b0};
                n_state = S_DBMUL;
            end
            S_DBMUL: begin
                n_prod  = mul_prod;
                n_state = S_DBRND;
            end
            S_DIV: begin
                n_rem  = ge ? CNT_W'(trial - {1'b0, r_count}) : CNT_W'(trial);
                n_acc  = {r_acc[SUM_W-2:0], ge};
                n_step = r_step + 1'b1;
                if (r_step == '1) begin
                    n_exp   = EXP_W'(SUM_W - 1);
                    n_state = S_NORM;
                end
            end
            S_OUT: begin
                if (i_ctrl.res_free) begin
                    n_peak  = '0;
                    n_sum   = '0;
                    n_count = '0;
                    n_clip  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_store) begin
            if (!r_sel) begin
                n_peak_db = db_val;
                n_sel     = 1'b1;
                if (r_count == '0) begin
                    n_acc   = '0;
                    n_exp   = EXP_W'(SUM_W - 1);
                    n_state = S_NORM;
                end else begin
                    n_acc   = r_sum;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end else begin
                n_rms_db = db_val;
                n_state  = S_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
            r_clip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_peak  <= n_peak;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_clip  <= n_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_last    <= n_last;
        r_upd     <= n_upd;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_exp     <= n_exp;
        r_man     <= n_man;
        r_frac    <= n_frac;
        r_cnt     <= n_cnt;
        r_d       <= n_d;
        r_sel     <= n_sel;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_peak_db <= n_peak_db;
        r_rms_db  <= n_rms_db;
    end

    assign o_stat.ready     = (r_state == S_IDLE);
    assign o_stat.res_valid = res_valid;

    assign o_res.peak_db          = r_peak_db;
    assign o_res.rms_db           = r_rms_db;
    assign o_res.dynamic_range_db = range;
    assign o_res.clipping         = r_clip;
    assign o_res.silent           = (r_rms_db < i_silence_thr);

endmodule
